// ===== rtl/core/wcp_pkg.sv =====
package wcp_pkg;

    localparam int SPLIT_W = 6;
    localparam int PAIR_W = 11;
    localparam int STAT_W = 32;
    localparam int WIDE_W = 64;

    // quotient bits: 64 integer bits of the numerator plus 60 fraction bits
    localparam int FRAC_BITS = 60;
    localparam int DIV_STEPS = WIDE_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [STAT_W-1:0] STAT_POS_MAX = {1'b0, {(STAT_W-1){1'b1}}};

    // request from the split sequencer to the normalizing unit
    typedef struct packed {
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] den;
        logic              neg;
    } norm_req_t;

endpackage

// ===== rtl/core/wilcoxon_change_point_statistic.sv =====
// sequence: after the marked request the states DEN1, DEN2 and DEN3 form n^5 in three
// multiplies, then each split runs a ring rotation, three multiplies, handoff, 124-step
// divide, 32-step root and done, and its result is strobed in the next cycle, so n-1
// results follow; throughput is one request per cycle while loading
// results are strobed on valid for one cycle; the receiver cannot stall
// reset clears the sample count, drop flag and sequencer; samples are not cleared
module wilcoxon_change_point_statistic
    import wcp_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        sample,
    input  logic                      last,
    output logic                      valid,
    output logic [SPLIT_W-1:0]        split_after,
    output logic [PAIR_W-1:0]         pair_count,
    output logic signed [STAT_W-1:0]  statistic,
    output logic                      overflowed,
    output logic                      final_res
);

    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = $clog2(MAX_SAMPLES);
    localparam int CW = 2 * NW;
    localparam int SB = SAMPLE_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEN1 = 4'd1;
    localparam logic [3:0] ST_DEN2 = 4'd2;
    localparam logic [3:0] ST_DEN3 = 4'd3;
    localparam logic [3:0] ST_PASS = 4'd4;
    localparam logic [3:0] ST_MUL1 = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_MUL3 = 4'd7;
    localparam logic [3:0] ST_NORM = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [NW-1:0]     count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     k_reg, k_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [CW-1:0]     pairs_reg, pairs_next;
    logic [SB-1:0]     x_reg, x_next;
    logic [SB-1:0]     xn_reg, xn_next;
    logic [CW-1:0]     m_reg, m_next;
    logic [WIDE_W-1:0] sq_reg, sq_next;
    logic [WIDE_W-1:0] n2_reg, n2_next;
    logic [WIDE_W-1:0] den_reg, den_next;
    norm_req_t         req_reg, req_next;
    logic              go_reg, go_next;

    logic              valid_reg;
    logic [SPLIT_W-1:0] split_reg;
    logic [PAIR_W-1:0] pcount_reg;
    logic [STAT_W-1:0] stat_reg;
    logic              ovf_reg;
    logic              fin_reg;

    logic              accept;
    logic              load;
    logic              shift_en;
    logic [SB-1:0]     v_in;
    logic [SB-1:0]     head_d;
    logic [SB-1:0]     tail;
    logic [SB-1:0]     cell_q [MAX_SAMPLES];
    logic [NW:0]       jsum;
    logic              jvalid;
    logic [NW:0]       j;
    logic [CW:0]       two_c;
    logic              neg;
    logic [CW-1:0]     ad;
    logic              norm_done;
    logic [STAT_W-1:0] norm_stat;
    logic              last_split;

    assign accept = start && (state_reg == ST_IDLE);
    assign load   = accept && (count_reg < NW'(MAX_SAMPLES));

    // sign bit flipped so unsigned order matches signed order
    assign v_in = SB'($unsigned(sample)) ^ {1'b1, {(SB-1){1'b0}}};

    // ring of sample cells: loads push at the head, passes rotate the tail back
    assign shift_en = load || (state_reg == ST_PASS);
    assign head_d   = load ? v_in : tail;
    assign tail     = cell_q[MAX_SAMPLES-1];

    generate
        for (genvar gi = 0; gi < MAX_SAMPLES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                wcp_cell #(.W(SB)) u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (head_d),
                    .q        (cell_q[gi])
                );
            end
            else
            begin : g_body
                wcp_cell #(.W(SB)) u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (cell_q[gi-1]),
                    .q        (cell_q[gi])
                );
            end
        end
    endgenerate

    // sample index at the tail during a pass
    assign jsum   = (NW+1)'(step_reg) + (NW+1)'(n_reg);
    assign jvalid = jsum >= (NW+1)'(MAX_SAMPLES);
    assign j      = jsum - (NW+1)'(MAX_SAMPLES);

    assign two_c = {pairs_reg, 1'b0};
    assign neg   = two_c < {1'b0, m_reg};
    assign ad    = neg ? CW'({1'b0, m_reg} - two_c) : CW'(two_c - {1'b0, m_reg});

    assign last_split = (k_reg + 1'b1) == n_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        pairs_next = pairs_reg;
        x_next     = x_reg;
        xn_next    = xn_reg;
        m_next     = m_reg;
        sq_next    = sq_reg;
        n2_next    = n2_reg;
        den_next   = den_reg;
        req_next   = req_reg;
        go_next    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (load)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next = load ? count_reg + 1'b1 : count_reg;
                        if (n_next < NW'(2))
                        begin
                            count_next = '0;
                            drop_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_DEN1;
                        end
                    end
                end
            end
            // den = n^5 in three multiplies
            ST_DEN1:
            begin
                n2_next    = WIDE_W'(CW'(n_reg) * CW'(n_reg));
                pairs_next = '0;
                k_next     = NW'(1);
                step_next  = '0;
                state_next = ST_DEN2;
            end
            ST_DEN2:
            begin
                n2_next    = WIDE_W'((2*CW)'(n2_reg[CW-1:0]) * (2*CW)'(n2_reg[CW-1:0]));
                state_next = ST_DEN3;
            end
            ST_DEN3:
            begin
                den_next   = WIDE_W'(n2_reg * n_reg);
                state_next = ST_PASS;
            end
            // one full rotation updates the pair count for split k
            ST_PASS:
            begin
                if (jvalid)
                begin
                    if ((j < (NW+1)'(k_reg) - 1'b1) && (tail > x_reg))
                    begin
                        pairs_next = pairs_reg - 1'b1;
                    end
                    if ((j >= (NW+1)'(k_reg)) && (x_reg > tail))
                    begin
                        pairs_next = pairs_reg + 1'b1;
                    end
                    if (j == (NW+1)'(k_reg) - 1'b1)
                    begin
                        x_next = tail;
                    end
                    if (j == (NW+1)'(k_reg))
                    begin
                        xn_next = tail;
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(MAX_SAMPLES - 1))
                begin
                    step_next  = '0;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                m_next     = CW'(CW'(k_reg) * CW'(n_reg - k_reg));
                x_next     = xn_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                sq_next      = WIDE_W'((2*CW)'(ad) * (2*CW)'(ad));
                req_next.neg = neg;
                state_next   = ST_MUL3;
            end
            ST_MUL3:
            begin
                req_next.num = WIDE_W'((sq_reg * m_reg) << 2);
                req_next.den = den_reg;
                go_next      = 1'b1;
                state_next   = ST_NORM;
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    if (last_split)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        pairs_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_PASS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    wcp_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .req   (req_reg),
        .done  (norm_done),
        .stat  (norm_stat)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            pairs_reg <= '0;
            go_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            pairs_reg <= pairs_next;
            go_reg    <= go_next;
            valid_reg <= (state_reg == ST_NORM) && norm_done;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        step_reg <= step_next;
        x_reg    <= x_next;
        xn_reg   <= xn_next;
        m_reg    <= m_next;
        sq_reg   <= sq_next;
        n2_reg   <= n2_next;
        den_reg  <= den_next;
        req_reg  <= req_next;
        if ((state_reg == ST_NORM) && norm_done)
        begin
            split_reg  <= SPLIT_W'(k_reg);
            pcount_reg <= PAIR_W'(pairs_reg);
            stat_reg   <= norm_stat;
            ovf_reg    <= drop_reg;
            fin_reg    <= last_split;
        end
    end

    assign busy        = state_reg != ST_IDLE;
    assign valid       = valid_reg;
    assign split_after = split_reg;
    assign pair_count  = pcount_reg;
    assign statistic   = stat_reg;
    assign overflowed  = ovf_reg;
    assign final_res   = fin_reg;

endmodule

// ===== rtl/core/wcp_cell.sv =====
module wcp_cell
    import wcp_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;

    // one sample of the ring, moves to the neighbor on every shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/wcp_norm.sv =====
module wcp_norm
    import wcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  norm_req_t         req,
    output logic              done,
    output logic [STAT_W-1:0] stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [WIDE_W-1:0]   num_reg, num_next;
    logic [WIDE_W-1:0]   den_reg, den_next;
    logic [WIDE_W-1:0]   rem_reg, rem_next;
    logic [WIDE_W-1:0]   q_reg, q_next;
    logic                sat_reg, sat_next;
    logic                neg_reg, neg_next;
    logic [WIDE_W-1:0]   v_reg, v_next;
    logic [WIDE_W-1:0]   r_reg, r_next;
    logic [WIDE_W-1:0]   bit_reg, bit_next;
    logic                done_reg, done_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;

    logic [WIDE_W:0]     rem_sh;
    logic                ge;
    logic [WIDE_W-1:0]   trial;
    logic [WIDE_W-1:0]   r_fin;
    logic [STAT_W:0]     rounded;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        sat_next   = sat_reg;
        neg_next   = neg_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        stat_next  = stat_reg;

        // restoring division, one quotient bit a cycle
        rem_sh = {rem_reg, num_reg[WIDE_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};

        // digit-by-digit square root, one result bit a cycle
        trial = r_reg + bit_reg;
        r_fin = (v_reg >= trial) ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
        rounded = (STAT_W+1)'((r_fin + 64'd1) >> 1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    num_next   = req.num;
                    den_next   = req.den;
                    neg_next   = req.neg;
                    rem_next   = '0;
                    q_next     = '0;
                    sat_next   = 1'b0;
                    step_next  = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next = num_reg << 1;
                rem_next = ge ? WIDE_W'(rem_sh - {1'b0, den_reg}) : WIDE_W'(rem_sh);
                sat_next = sat_reg | q_reg[WIDE_W-1];
                q_next   = {q_reg[WIDE_W-2:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    v_next     = (sat_reg | q_reg[WIDE_W-1]) ? '1 : {q_reg[WIDE_W-2:0], ge};
                    r_next     = '0;
                    bit_next   = {2'b01, {(WIDE_W-2){1'b0}}};
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_next = v_reg - trial;
                end
                r_next   = r_fin;
                bit_next = bit_reg >> 2;
                if (bit_reg == WIDE_W'(1))
                begin
                    done_next = 1'b1;
                    if (neg_reg)
                    begin
                        stat_next = STAT_W'(~rounded + 1'b1);
                    end
                    else if (rounded > {1'b0, STAT_POS_MAX})
                    begin
                        stat_next = STAT_POS_MAX;
                    end
                    else
                    begin
                        stat_next = rounded[STAT_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
        neg_reg  <= neg_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        stat_reg <= stat_next;
    end

    assign done = done_reg;
    assign stat = stat_reg;

endmodule

// ===== test/wilcoxon_change_point_statistic_tb.sv =====
`timescale 1ns / 1ps

module wilcoxon_change_point_statistic_tb;
    import wcp_pkg::*;

    localparam int CAP = 64;
    localparam int WATCH_LIMIT = 4000;

    typedef struct {
        logic [SPLIT_W-1:0] split;
        logic [PAIR_W-1:0] pairs;
        logic signed [STAT_W-1:0] stat;
        logic ovf;
        logic fin;
    } split_result_t;

    // expected split results for the series being loaded
    class split_scoreboard;
        logic signed [31:0] series[$];
        logic dropped;
        split_result_t pending_splits[$];
        int errors;
        int results_seen;
        int series_done;

        function new();
            dropped = 0;
            errors = 0;
            results_seen = 0;
            series_done = 0;
        endfunction

        // normalized statistic in Q2.29, n samples, m = k(n-k), c pairs
        function logic [31:0] norm_q30(int unsigned n, int unsigned m, int unsigned c);
            logic neg;
            logic [63:0] ad, num, den, q, rem, v, root, bitv, r;
            logic sat;
            neg = (2 * c) < m;
            ad = neg ? 64'(m - 2 * c) : 64'(2 * c - m);
            num = 64'd4 * 64'(m) * ad * ad;
            den = 64'(n) * n * n * n * n;
            q = num / den;
            rem = num % den;
            sat = 0;
            for (int b = 0; b < 60; b++)
            begin
                if (q[63])
                    sat = 1;
                q = q << 1;
                rem = rem << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q[0] = 1'b1;
                end
            end
            if (sat)
                q = '1;
            // integer square root, bit by bit
            v = q;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            r = (root + 1) >> 1;
            if (!neg)
                return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
            return 32'(0 - r);
        endfunction

        // note one accepted request
        function void note_request(logic signed [31:0] s, logic l);
            int n, cnt;
            split_result_t e;
            if (series.size() < CAP)
                series.push_back(s);
            else
                dropped = 1;
            if (!l)
                return;
            n = series.size();
            for (int k = 1; k < n; k++)
            begin
                cnt = 0;
                for (int i = 0; i < k; i++)
                    for (int j = k; j < n; j++)
                        if (series[i] > series[j])
                            cnt++;
                e.split = k[SPLIT_W-1:0];
                e.pairs = cnt[PAIR_W-1:0];
                e.stat = norm_q30(n, k * (n - k), cnt);
                e.ovf = dropped;
                e.fin = (k + 1 == n);
                pending_splits.push_back(e);
            end
            series.delete();
            dropped = 0;
            series_done++;
        endfunction

        // compare one strobed result with the oldest expectation
        function void check_result(split_result_t got);
            split_result_t e;
            results_seen++;
            if (pending_splits.size() == 0)
            begin
                $error("unexpected result, split_after %0d", got.split);
                errors++;
                return;
            end
            e = pending_splits.pop_front();
            if (got.split !== e.split)
            begin
                $error("split_after: expected %0d, got %0d", e.split, got.split);
                errors++;
            end
            if (got.pairs !== e.pairs)
            begin
                $error("pair_count: expected %0d, got %0d", e.pairs, got.pairs);
                errors++;
            end
            if (got.stat !== e.stat)
            begin
                $error("statistic: expected %0d, got %0d", e.stat, got.stat);
                errors++;
            end
            if (got.ovf !== e.ovf)
            begin
                $error("overflowed: expected %0d, got %0d", e.ovf, got.ovf);
                errors++;
            end
            if (got.fin !== e.fin)
            begin
                $error("final_res: expected %0d, got %0d", e.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] sample;
    logic last;
    logic valid;
    logic [SPLIT_W-1:0] split_after;
    logic [PAIR_W-1:0] pair_count;
    logic signed [STAT_W-1:0] statistic;
    logic overflowed;
    logic final_res;

    split_scoreboard sb;
    int idle_cycles;
    bit allow_idle;
    bit took_request;
    int rand_items;

    wilcoxon_change_point_statistic DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .sample(sample),
        .last(last),
        .valid(valid),
        .split_after(split_after),
        .pair_count(pair_count),
        .statistic(statistic),
        .overflowed(overflowed),
        .final_res(final_res)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        split_result_t got;
        if (rst_n)
        begin
            if (valid)
            begin
                got.split = split_after;
                got.pairs = pair_count;
                got.stat = statistic;
                got.ovf = overflowed;
                got.fin = final_res;
                sb.check_result(got);
            end
            if (valid || took_request)
                idle_cycles = 0;
            else
                idle_cycles++;
            took_request = 0;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("timeout: no activity for %0d cycles", WATCH_LIMIT);
                $display("wilcoxon_change_point_statistic_tb: done, errors");
                $finish;
            end
        end
    end

    // drive one request, with random idle cycles before it when allow_idle is set
    task send_sample(input logic signed [31:0] s, input logic l);
        @(negedge clk);
        while (allow_idle && $urandom_range(99) < 24)
        begin
            start = 0;
            sample = $urandom;
            last = $urandom_range(1);
            @(negedge clk);
        end
        start = 1;
        sample = s;
        last = l;
        do
            @(posedge clk);
        while (busy);
        took_request = 1;
        sb.note_request(s, l);
    endtask

    task drain();
        @(negedge clk);
        start = 0;
        while (sb.pending_splits.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function logic signed [31:0] pick_value(int mode);
        case (mode)
            0: return $signed(32'($urandom_range(7))) - 3;
            1: return $urandom;
            default: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // send a series of len requests, last one marked
    task send_series(int len, int mode);
        for (int i = 0; i < len; i++)
            send_sample(pick_value(mode), i == len - 1);
    endtask

    initial
    begin
        int len;
        sb = new();
        idle_cycles = 0;
        took_request = 0;
        allow_idle = 1;
        start = 0;
        sample = 0;
        last = 0;
        rst_n = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: single samples, extremes, ties, monotone runs
        send_sample(32'h7FFF_FFFF, 1);
        send_sample(32'h8000_0000, 1);
        send_sample(32'h7FFF_FFFF, 0);
        send_sample(32'h8000_0000, 1);
        send_sample(32'h8000_0000, 0);
        send_sample(32'h7FFF_FFFF, 1);
        for (int i = 0; i < 4; i++)
            send_sample(32'sd5, i == 3);
        for (int i = 0; i < 5; i++)
            send_sample(32'sd100 - 32'sd40 * i, i == 4);
        for (int i = 0; i < 5; i++)
            send_sample(-32'sd7 + 32'sd3 * i, i == 4);
        send_sample(32'h5555_5555, 0);
        send_sample(32'hAAAA_AAAA, 0);
        send_sample(32'h0000_0000, 0);
        send_sample(32'hFFFF_FFFF, 1);
        // hold off until every split result is out
        drain();

        // random: store filled past capacity with a dropped marked sample, no idling
        allow_idle = 0;
        send_series(CAP + 3, 1);
        allow_idle = 1;
        rand_items = 0;
        while (rand_items < 40)
        begin
            allow_idle = (sb.series_done % 5) != 2;
            len = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(12, 2);
            send_series(len, $urandom_range(2));
            rand_items += len;
        end
        drain();

        $display("covered %0d series, %0d split results, incl. full and overflowed stores",
                 sb.series_done, sb.results_seen);
        if (sb.errors == 0 && sb.pending_splits.size() == 0)
            $display("wilcoxon_change_point_statistic_tb: done, clean");
        else
            $display("wilcoxon_change_point_statistic_tb: done, errors");
        $finish;
    end

endmodule
